@@ rtl/core/wis_pkg.sv @@
`default_nettype none

package wis_pkg;

  localparam int COUNT_W    = 9;
  localparam int INDEX_W    = 8;
  localparam int FRACTION_W = 32;
  localparam int LOAD_W     = 32;
  localparam int RESULT_W   = 8;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_DRAW = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TOT   = 7'b0000010,
    ST_MHI   = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_ISSUE = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load_we;
    logic draw_start;
    logic mul_lo;
    logic mul_hi;
    logic sum_thr;
    logic step_cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic search_more;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/wis_ctrl.sv @@
`default_nettype none

module wis_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_action,
  output logic                  in_tready,
  input  wire wis_pkg::status_t status,
  output wis_pkg::cmd_t         cmd
);

  wis_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign in_tready = (state_r == wis_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd            = '0;
    cmd.load_we    = accept && (in_action == wis_pkg::ACTION_LOAD);
    cmd.draw_start = accept && (in_action == wis_pkg::ACTION_DRAW);
    cmd.mul_lo     = (state_r == wis_pkg::ST_TOT);
    cmd.mul_hi     = (state_r == wis_pkg::ST_MHI);
    cmd.sum_thr    = (state_r == wis_pkg::ST_SUM);
    cmd.step_cmp   = (state_r == wis_pkg::ST_CMP);
    cmd.out_load   = (state_r == wis_pkg::ST_DONE) && status.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wis_pkg::ST_IDLE: begin
        if (cmd.draw_start) begin
          state_nxt = wis_pkg::ST_TOT;
        end
      end
      wis_pkg::ST_TOT:  state_nxt = wis_pkg::ST_MHI;
      wis_pkg::ST_MHI:  state_nxt = wis_pkg::ST_SUM;
      wis_pkg::ST_SUM:  state_nxt = wis_pkg::ST_ISSUE;
      wis_pkg::ST_ISSUE: begin
        if (status.search_more) begin
          state_nxt = wis_pkg::ST_CMP;
        end else begin
          state_nxt = wis_pkg::ST_DONE;
        end
      end
      wis_pkg::ST_CMP:  state_nxt = wis_pkg::ST_ISSUE;
      wis_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_nxt = wis_pkg::ST_IDLE;
        end
      end
      default:          state_nxt = wis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wis_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wis_dp.sv @@
`default_nettype none

module wis_dp #(
  parameter int MAX_ENTRIES = 256,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire wis_pkg::cmd_t                    cmd,
  output wis_pkg::status_t                      status,
  input  wire logic [wis_pkg::COUNT_W-1:0]      entry_count,
  input  wire logic [wis_pkg::INDEX_W-1:0]      entry_index,
  input  wire logic [wis_pkg::LOAD_W-1:0]       entry_weight,
  input  wire logic [wis_pkg::FRACTION_W-1:0]   random_fraction,
  input  wire logic                             out_tready,
  output logic                                  out_tvalid,
  output logic [wis_pkg::RESULT_W-1:0]          chosen_index
);

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int HIW = (WEIGHT_BITS > 32) ? WEIGHT_BITS - 32 : 1;

  logic [WEIGHT_BITS-1:0] mem_r [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0] rdata_r;

  logic [wis_pkg::FRACTION_W-1:0] u_r;
  logic [31:0]            prod_lo_r;
  logic [HIW-1:0]         tot_hi_r;
  logic [WEIGHT_BITS-1:0] prod_hi_r;
  logic [WEIGHT_BITS-1:0] thr_r;
  logic [AW-1:0]          hi_r;
  logic [AW-1:0]          lo_p1_r;
  logic                   out_tvalid_r;
  logic [wis_pkg::RESULT_W-1:0] chosen_r;

  logic [AW-1:0] last_idx;
  logic [AW-1:0] mid;
  logic [AW:0]   mid_sum;
  logic [AW-1:0] rd_addr;
  logic          load_ok;
  logic [63:0]   tot64;
  logic [31:0]   mul_b;
  logic [63:0]   mul_p;

  // n clamped to 1..MAX_ENTRIES, kept as n-1
  always_comb begin
    if (entry_count == '0) begin
      last_idx = '0;
    end else if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
      last_idx = AW'(MAX_ENTRIES - 1);
    end else begin
      last_idx = AW'(entry_count - 9'd1);
    end
  end

  // lo is held as lo+1 so it never goes negative
  assign mid_sum = {1'b0, hi_r} + {1'b0, lo_p1_r} - (AW+1)'(1);
  assign mid     = mid_sum[AW:1];
  assign rd_addr = cmd.draw_start ? last_idx : mid;
  assign load_ok = 32'(entry_index) < 32'(MAX_ENTRIES);

  assign tot64 = 64'(rdata_r);
  assign mul_b = cmd.mul_hi ? 32'(tot_hi_r) : tot64[31:0];
  assign mul_p = 64'(u_r) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.load_we && load_ok) begin
      mem_r[AW'(entry_index)] <= WEIGHT_BITS'(entry_weight);
    end
    rdata_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_start) begin
      u_r     <= random_fraction;
      hi_r    <= last_idx;
      lo_p1_r <= '0;
    end
    if (cmd.mul_lo) begin
      prod_lo_r <= mul_p[63:32];
      tot_hi_r  <= HIW'(tot64[63:32]);
    end
    if (cmd.mul_hi) begin
      prod_hi_r <= WEIGHT_BITS'(mul_p);
    end
    if (cmd.sum_thr) begin
      thr_r <= prod_hi_r + WEIGHT_BITS'(prod_lo_r);
    end
    if (cmd.step_cmp) begin
      if (rdata_r <= thr_r) begin
        lo_p1_r <= AW'(mid + AW'(1));
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.out_load) begin
      chosen_r <= wis_pkg::RESULT_W'(hi_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign status.search_more = hi_r > lo_p1_r;
  assign status.out_free    = !out_tvalid_r || out_tready;
  assign out_tvalid         = out_tvalid_r;
  assign chosen_index       = chosen_r;

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_cmp |=> (lo_p1_r <= hi_r))
    else $error("search bounds crossed");

  a_bounds_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_cmp |=> ((hi_r - lo_p1_r) < $past(hi_r - lo_p1_r)))
    else $error("search step made no progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

@@ rtl/core/weighted_index_sampler_core.sv @@
// Load transfer: written to the table in the accepting cycle; ready again next cycle.
// Draw transfer: the result register is loaded after states TOT, MHI and SUM, one ISSUE/CMP pair
//   per bisection step around the single synchronous table read, a final ISSUE, then DONE.
// One draw at a time; the next item is taken while a result waits.
// Reset (rst_n low, synchronous): controller idle, no result pending, entry_count = 1.
// Table contents are not cleared by reset.
`default_nettype none

module weighted_index_sampler_core #(
  parameter int MAX_ENTRIES = 256,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] entry_index, [39:8] entry_weight, [71:40] random_fraction
  input  wire logic [71:0] in_tdata,
  // [0] action
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] chosen_index
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata
);

  logic [wis_pkg::COUNT_W-1:0] entry_count_r;
  wis_pkg::cmd_t               cmd;
  wis_pkg::status_t            status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= wis_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  wis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser[0]),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wis_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .entry_count     (entry_count_r),
    .entry_index     (in_tdata[7:0]),
    .entry_weight    (in_tdata[39:8]),
    .random_fraction (in_tdata[71:40]),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .chosen_index    (out_tdata)
  );

endmodule

`default_nettype wire

@@ verif/weighted_index_sampler_core_test.sv @@
`default_nettype none

module weighted_index_sampler_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = 256;
  localparam int ITEM_TARGET   = 800;
  localparam int DRAWS_PER_SET = 50;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;

  typedef logic [wis_pkg::COUNT_W-1:0]    count_t;
  typedef logic [wis_pkg::INDEX_W-1:0]    index_t;
  typedef logic [wis_pkg::LOAD_W-1:0]     weight_t;
  typedef logic [wis_pkg::FRACTION_W-1:0] frac_t;
  typedef logic [wis_pkg::RESULT_W-1:0]   pick_t;

  typedef struct packed {
    logic    is_cfg;
    logic    action;
    index_t  index;
    weight_t weight;   // register value on a cfg row
    frac_t   fraction;
    logic    typed;
    pick_t   want;
  } step_t;

  localparam int DIRECTED_ROWS = 21;
  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, wis_pkg::ACTION_LOAD, 8'd0,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, 8'd0},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0},
    '{1'b0, wis_pkg::ACTION_LOAD, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_LOAD, 8'd0,   32'd10,        32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_LOAD, 8'd1,   32'd20,        32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_LOAD, 8'd2,   32'd30,        32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_LOAD, 8'd3,   32'd40,        32'h0000_0000, 1'b0, 8'd0},
    '{1'b1, wis_pkg::ACTION_LOAD, 8'd0,   32'd4,         32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, 8'd0},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 8'd3},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'h8000_0000, 1'b1, 8'd2},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'h4000_0000, 1'b0, 8'd0},
    // non-monotone table
    '{1'b0, wis_pkg::ACTION_LOAD, 8'd1,   32'd5,         32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'h9E37_79B9, 1'b0, 8'd0},
    // zero total
    '{1'b0, wis_pkg::ACTION_LOAD, 8'd3,   32'd0,         32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 8'd0},
    // zero count acts as one entry
    '{1'b1, wis_pkg::ACTION_LOAD, 8'd0,   32'd0,         32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'h1234_5678, 1'b1, 8'd0},
    '{1'b1, wis_pkg::ACTION_LOAD, 8'd0,   32'd1,         32'h0000_0000, 1'b0, 8'd0},
    '{1'b0, wis_pkg::ACTION_DRAW, 8'd0,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 8'd0}
  };

  localparam count_t SET_COUNTS [10] = '{
    9'd256, 9'd1, 9'd0, 9'd511, 9'd2, 9'd3, 9'd7, 9'd64, 9'd100, 9'd33
  };

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // [7:0] entry_index, [39:8] entry_weight, [71:40] random_fraction
  logic [71:0]         in_tdata   = '0;
  logic [0:0]          in_tuser   = '0;  // [0] action
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;        // [7:0] chosen_index
  logic                cfg_we     = 1'b0;
  count_t              cfg_wdata  = '0;

  weighted_index_sampler_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  weight_t weight_table [TABLE_DEPTH];
  count_t  entry_count_q = 9'd1;
  pick_t   pending_picks [$];
  pick_t   want_pick;

  int errors        = 0;
  int items_sent    = 0;
  int loads_sent    = 0;
  int draws_sent    = 0;
  int picks_seen    = 0;
  int settings_seen = 0;
  int tx_idle_pct   = 36;
  int rx_idle_pct   = 69;
  bit hold_req      = 1'b0;
  bit hold_taken    = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  function automatic int active_entries(input count_t count);
    if (count == 0) return 1;
    if (count > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(count);
  endfunction

  // threshold = floor(u * total / 2^32), then first index whose weight exceeds it (last index if none does)
  function automatic pick_t predict_pick(input frac_t frac);
    int n, lo, hi, mid;
    logic [63:0] prod;
    logic [31:0] thr;
    n    = active_entries(entry_count_q);
    prod = 64'(frac) * 64'(weight_table[n-1]);
    thr  = prod[63:32];
    lo   = -1;
    hi   = n - 1;
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      if (weight_table[mid] <= thr) lo = mid;
      else hi = mid;
    end
    return hi[wis_pkg::RESULT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input pick_t got, input pick_t want);
    $display("ERROR %0t: %s: chosen_index got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_item(input logic action, input index_t idx,
                           input weight_t weight, input frac_t frac,
                           input logic typed, input pick_t want);
    if (items_sent < 270) begin
      tx_idle_pct = 36;
      rx_idle_pct = 69;
    end else if (items_sent < 540) begin
      tx_idle_pct = 69;
      rx_idle_pct = 36;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    if (items_sent == HOLD_AT) hold_req = 1'b1;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {frac, weight, idx};
    in_tuser  <= action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (action == wis_pkg::ACTION_LOAD) begin
      weight_table[idx] = weight;
      loads_sent++;
    end else begin
      pending_picks.push_back(typed ? want : predict_pick(frac));
      draws_sent++;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_picks();
    in_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input count_t value);
    drain_picks();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    entry_count_q = value;
    settings_seen++;
  endtask

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      picks_seen++;
      if (pending_picks.size() == 0) begin
        report_mismatch("transfer with no draw pending", out_tdata, '0);
      end else begin
        want_pick = pending_picks.pop_front();
        if (out_tdata !== want_pick) report_mismatch("wrong index", out_tdata, want_pick);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d draws pending",
               quiet_cycles, pending_picks.size());
      $display("weighted_index_sampler_core: mismatch");
      $finish;
    end
  end

  initial begin
    int set_no;
    int n;
    int style;
    weight_t acc;
    frac_t frac;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      if (DIRECTED[k].is_cfg) begin
        write_count(DIRECTED[k].weight[wis_pkg::COUNT_W-1:0]);
      end else begin
        send_item(DIRECTED[k].action, DIRECTED[k].index, DIRECTED[k].weight,
                  DIRECTED[k].fraction, DIRECTED[k].typed, DIRECTED[k].want);
      end
    end

    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      write_count(set_no < 10 ? SET_COUNTS[set_no] : count_t'($urandom_range(0, 511)));
      n = active_entries(entry_count_q);
      // first set fills the whole table so later draws never read stale entries
      if (set_no == 0 || n <= 64) begin
        style = $urandom_range(0, 1);
        acc   = (style == 0) ? '0 : weight_t'($urandom_range(0, 3));
        for (int i = 0; i < n; i++) begin
          if (style == 0) acc = acc + weight_t'($urandom_range(0, 3));
          else acc = acc + weight_t'($urandom_range(0, 32'hFFFF_FFFC / n));
          send_item(wis_pkg::ACTION_LOAD, index_t'(i), acc, $urandom(), 1'b0, '0);
        end
      end
      repeat (DRAWS_PER_SET) begin
        case ($urandom_range(0, 9))
          0:       frac = '0;
          1:       frac = '1;
          default: frac = $urandom();
        endcase
        if ($urandom_range(0, 9) == 0) begin
          send_item(wis_pkg::ACTION_LOAD, index_t'($urandom_range(0, 255)), $urandom(), frac,
                    1'b0, '0);
        end else begin
          send_item(wis_pkg::ACTION_DRAW, index_t'($urandom_range(0, 255)), $urandom(), frac,
                    1'b0, '0);
        end
      end
      set_no++;
    end

    drain_picks();
    $display("run covered %0d transfers in (%0d loads, %0d draws) over %0d entry-count settings",
             items_sent, loads_sent, draws_sent, settings_seen);
    $display("%0d picks checked, %0d errors", picks_seen, errors);
    if (errors == 0) begin
      $display("weighted_index_sampler_core: match");
    end else begin
      $display("weighted_index_sampler_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
